FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; define NO_ASSERTIONS to compile out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

FILE: rtl/dmcc_pkg.sv
// ----------------------------------------------------------------------------
// dmcc_pkg
// Types, register codes and counter helpers of the direct-mapped cache
// controller.
// ----------------------------------------------------------------------------
package dmcc_pkg;

  localparam int CNT_W   = 32;
  localparam int NUM_CNT = 8;
  localparam int CFG_W   = 4;
  // block size is 1 << block shift, block shift at most 15
  localparam int BLK_W   = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // reset values of the configuration registers
  localparam logic             WB_RESET = 1'b1;
  localparam logic [CFG_W-1:0] IB_RESET = 4'd9;
  localparam logic [CFG_W-1:0] OB_RESET = 4'd2;

  typedef enum logic [1:0] {
    REG_WRITE_BACK = 2'd0,
    REG_INDEX_BITS = 2'd1,
    REG_BLK_SHIFT  = 2'd2
  } reg_idx_e;

  // statistics counter slots
  localparam logic [2:0] CNT_CPU_READS    = 3'd0;
  localparam logic [2:0] CNT_CPU_WRITES   = 3'd1;
  localparam logic [2:0] CNT_MEM_READS    = 3'd2;
  localparam logic [2:0] CNT_MEM_WRITES   = 3'd3;
  localparam logic [2:0] CNT_READ_HITS    = 3'd4;
  localparam logic [2:0] CNT_READ_MISSES  = 3'd5;
  localparam logic [2:0] CNT_WRITE_HITS   = 3'd6;
  localparam logic [2:0] CNT_WRITE_MISSES = 3'd7;

  typedef struct packed {
    logic                           hit;
    logic                           wrote_back;
    logic [NUM_CNT-1:0][CNT_W-1:0]  cnt;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } bk_status_t;

  // Add with saturation at the counter maximum
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                               input logic [BLK_W-1:0] amt);
    logic [CNT_W:0] s;
    s = {1'b0, v} + {{(CNT_W+1-BLK_W){1'b0}}, amt};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

FILE: rtl/direct_mapped_cache_controller_top.sv
// ----------------------------------------------------------------------------
// direct_mapped_cache_controller_top
// Flow: the back end pops an access and registers its line store read, then
// updates the line and pushes a result beat; a full result queue stalls it,
// and it pops no new access until that beat is pushed.
// Reset: config returns to write-back, 9 index bits, 2 offset bits; counters
// clear; a sweep clears all 2**floor(log2(MAX_LINES)) lines, full high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module direct_mapped_cache_controller_top #(
  parameter int MAX_LINES  = 512,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // access side
  input  logic                  push,
  output logic                  full,
  input  logic                  op_i,
  input  logic [ADDR_WIDTH-1:0] address_i,
  // result side
  output logic                  empty,
  input  logic                  pop,
  output logic                  hit_o,
  output logic                  wrote_back_o,
  output logic [31:0]           cpu_reads_o,
  output logic [31:0]           cpu_writes_o,
  output logic [31:0]           mem_read_words_o,
  output logic [31:0]           mem_write_words_o,
  output logic [31:0]           read_hits_o,
  output logic [31:0]           read_misses_o,
  output logic [31:0]           write_hits_o,
  output logic [31:0]           write_misses_o
);

  localparam int MIB         = $clog2(MAX_LINES + 1) - 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QW          = 1 + dmcc_pkg::CFG_W + MIB + ADDR_WIDTH;
  localparam int RW          = $bits(dmcc_pkg::res_t);

  logic                       wb_q;
  logic [dmcc_pkg::CFG_W-1:0] ib_q, ob_q;
  logic                       cfg_we;
  dmcc_pkg::reg_idx_e         reg_sel;

  logic                       fe_write;
  logic [dmcc_pkg::CFG_W-1:0] fe_ob;
  logic [MIB-1:0]             fe_idx;
  logic [ADDR_WIDTH-1:0]      fe_tag;

  logic                       fq_push, fq_full, fq_empty, fq_pop;
  logic [QW-1:0]              fq_rdata;

  logic                       res_push, res_full;
  dmcc_pkg::res_t             res_wdata, res_rdata;
  dmcc_pkg::bk_status_t       bk_status;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign reg_sel = dmcc_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q <= dmcc_pkg::WB_RESET;
      ib_q <= dmcc_pkg::IB_RESET;
      ob_q <= dmcc_pkg::OB_RESET;
    end else if (cfg_we) begin
      case (reg_sel)
        dmcc_pkg::REG_WRITE_BACK: wb_q <= pwdata[0];
        dmcc_pkg::REG_INDEX_BITS: ib_q <= pwdata[dmcc_pkg::CFG_W-1:0];
        dmcc_pkg::REG_BLK_SHIFT:  ob_q <= pwdata[dmcc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    case (reg_sel)
      dmcc_pkg::REG_WRITE_BACK: prdata = {31'b0, wb_q};
      dmcc_pkg::REG_INDEX_BITS: prdata = {{(32-dmcc_pkg::CFG_W){1'b0}}, ib_q};
      dmcc_pkg::REG_BLK_SHIFT:  prdata = {{(32-dmcc_pkg::CFG_W){1'b0}}, ob_q};
      default:                  prdata = '0;
    endcase
  end

  // Front end: split the address
  dmcc_front #(
    .MIB        (MIB),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_front (
    .op_i          (op_i),
    .address_i     (address_i),
    .index_bits_i  (ib_q),
    .blk_shift_i   (ob_q),
    .is_write_o    (fe_write),
    .ob_o          (fe_ob),
    .idx_o         (fe_idx),
    .tag_o         (fe_tag)
  );

  // Hold off accesses while the line store is swept
  assign full    = fq_full | bk_status.clearing;
  assign fq_push = push & ~full;

  dmcc_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_access_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .wdata_i ({fe_write, fe_ob, fe_idx, fe_tag}),
    .full_o  (fq_full),
    .pop_i   (fq_pop),
    .rdata_o (fq_rdata),
    .empty_o (fq_empty)
  );

  // Back end: lookup, update, count
  dmcc_back #(
    .IDX_W      (MIB),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .write_back_i (wb_q),
    .q_empty_i    (fq_empty),
    .q_pop_o      (fq_pop),
    .q_is_write_i (fq_rdata[QW-1]),
    .q_ob_i       (fq_rdata[QW-2 -: dmcc_pkg::CFG_W]),
    .q_idx_i      (fq_rdata[ADDR_WIDTH +: MIB]),
    .q_tag_i      (fq_rdata[ADDR_WIDTH-1:0]),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_data_o   (res_wdata),
    .status_o     (bk_status)
  );

  // Result queue
  logic [RW-1:0] res_rbits;

  dmcc_fifo #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wdata),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rbits),
    .empty_o (empty)
  );

  assign res_rdata         = dmcc_pkg::res_t'(res_rbits);
  assign hit_o             = res_rdata.hit;
  assign wrote_back_o      = res_rdata.wrote_back;
  assign cpu_reads_o       = res_rdata.cnt[dmcc_pkg::CNT_CPU_READS];
  assign cpu_writes_o      = res_rdata.cnt[dmcc_pkg::CNT_CPU_WRITES];
  assign mem_read_words_o  = res_rdata.cnt[dmcc_pkg::CNT_MEM_READS];
  assign mem_write_words_o = res_rdata.cnt[dmcc_pkg::CNT_MEM_WRITES];
  assign read_hits_o       = res_rdata.cnt[dmcc_pkg::CNT_READ_HITS];
  assign read_misses_o     = res_rdata.cnt[dmcc_pkg::CNT_READ_MISSES];
  assign write_hits_o      = res_rdata.cnt[dmcc_pkg::CNT_WRITE_HITS];
  assign write_misses_o    = res_rdata.cnt[dmcc_pkg::CNT_WRITE_MISSES];

  // Checks
  `ASSERT_PROP(a_clear_no_result, clk_i, rst_ni, bk_status.clearing |-> empty, "result during line clear")
  `ASSERT_NEVER(a_res_overflow, clk_i, rst_ni, res_push && res_full, "result beat into full queue")
  `ASSERT_PROP(a_hit_no_wb, clk_i, rst_ni, res_push && res_wdata.hit |-> !res_wdata.wrote_back, "write back on hit")
  `ASSERT_PROP(a_pop_then_look, clk_i, rst_ni, fq_pop |=> bk_status.busy, "popped access not looked up")

endmodule

FILE: rtl/dmcc_fifo.sv
// ----------------------------------------------------------------------------
// dmcc_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module dmcc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push_fire, pop_fire;

  assign full_o    = (count_q == CNT_W'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign push_fire = push_i & ~full_o;
  assign pop_fire  = pop_i & ~empty_o;
  assign rdata_o   = data_q[rd_ptr_q];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_fire) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      count_d = count_q + 1'b1;
    end else if (!push_fire && pop_fire) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      data_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/dmcc_front.sv
// ----------------------------------------------------------------------------
// dmcc_front
// Splits a CPU access address into line index and tag for the configured
// geometry.
// ----------------------------------------------------------------------------
module dmcc_front #(
  parameter int MIB        = 9,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                        op_i,
  input  logic [ADDR_WIDTH-1:0]       address_i,
  input  logic [dmcc_pkg::CFG_W-1:0]  index_bits_i,
  input  logic [dmcc_pkg::CFG_W-1:0]  blk_shift_i,
  output logic                        is_write_o,
  output logic [dmcc_pkg::CFG_W-1:0]  ob_o,
  output logic [MIB-1:0]              idx_o,
  output logic [ADDR_WIDTH-1:0]       tag_o
);

  localparam int SH_W = dmcc_pkg::CFG_W + 2;

  logic [dmcc_pkg::CFG_W-1:0] ib;
  logic [MIB-1:0]             idx_mask;
  logic [ADDR_WIDTH-1:0]      shifted;
  logic [SH_W-1:0]            tag_shamt;

  // Clamp the index width to the lines that exist
  assign ib = (index_bits_i > dmcc_pkg::CFG_W'(MIB)) ? dmcc_pkg::CFG_W'(MIB) : index_bits_i;

  // Build the index mask from the clamped width
  always_comb begin
    for (int i = 0; i < MIB; i++) begin
      idx_mask[i] = (dmcc_pkg::CFG_W'(i) < ib);
    end
  end

  // Drop the block offset, then take index and tag
  assign shifted    = address_i >> blk_shift_i;
  assign idx_o      = shifted[MIB-1:0] & idx_mask;
  assign tag_shamt  = {2'b00, blk_shift_i} + {2'b00, ib};
  assign tag_o      = address_i >> tag_shamt;
  assign is_write_o = op_i;
  assign ob_o       = blk_shift_i;

endmodule

FILE: rtl/dmcc_back.sv
// ----------------------------------------------------------------------------
// dmcc_back
// Line store lookup and update, victim handling and statistics counters.
// ----------------------------------------------------------------------------
module dmcc_back #(
  parameter int IDX_W      = 9,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        write_back_i,
  input  logic                        q_empty_i,
  output logic                        q_pop_o,
  input  logic                        q_is_write_i,
  input  logic [dmcc_pkg::CFG_W-1:0]  q_ob_i,
  input  logic [IDX_W-1:0]            q_idx_i,
  input  logic [ADDR_WIDTH-1:0]       q_tag_i,
  input  logic                        res_full_i,
  output logic                        res_push_o,
  output dmcc_pkg::res_t              res_data_o,
  output dmcc_pkg::bk_status_t        status_o
);

  localparam int LINES = 2 ** IDX_W;
  localparam int LW    = ADDR_WIDTH + 2;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;

  // current item
  logic                       it_write_q;
  logic [dmcc_pkg::CFG_W-1:0] it_ob_q;
  logic [IDX_W-1:0]           it_idx_q;
  logic [ADDR_WIDTH-1:0]      it_tag_q;

  // line store: {valid, dirty, tag}
  logic [LW-1:0]    line_mem_q [LINES];
  logic [LW-1:0]    line_rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [LW-1:0]    mem_wd;

  logic [dmcc_pkg::NUM_CNT-1:0][dmcc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [dmcc_pkg::NUM_CNT-1:0][dmcc_pkg::BLK_W-1:0] amt;

  logic                       look_fire;
  logic                       rd_valid, rd_dirty;
  logic [ADDR_WIDTH-1:0]      rd_tag;
  logic                       hit, victim, dirty_new, wr_wb;
  logic [dmcc_pkg::BLK_W-1:0] block;

  assign q_pop_o   = (state_q == S_IDLE) && !q_empty_i;
  assign look_fire = (state_q == S_LOOK) && !res_full_i;
  assign rd_addr   = (state_q == S_IDLE) ? q_idx_i : it_idx_q;

  // Classify the lookup
  assign rd_valid  = line_rd_q[LW-1];
  assign rd_dirty  = line_rd_q[LW-2];
  assign rd_tag    = line_rd_q[ADDR_WIDTH-1:0];
  assign hit       = rd_valid && (rd_tag == it_tag_q);
  assign wr_wb     = it_write_q && write_back_i;
  assign victim    = !hit && write_back_i && rd_valid && rd_dirty;
  assign dirty_new = hit ? (rd_dirty | wr_wb) : wr_wb;
  assign block     = dmcc_pkg::BLK_W'(1) << it_ob_q;

  // Counter increments for this access
  always_comb begin
    amt = '0;
    amt[dmcc_pkg::CNT_CPU_READS]    = dmcc_pkg::BLK_W'(!it_write_q);
    amt[dmcc_pkg::CNT_CPU_WRITES]   = dmcc_pkg::BLK_W'(it_write_q);
    amt[dmcc_pkg::CNT_MEM_READS]    = hit ? '0 : block;
    amt[dmcc_pkg::CNT_MEM_WRITES]   = victim ? block
                                    : dmcc_pkg::BLK_W'(it_write_q && !write_back_i);
    amt[dmcc_pkg::CNT_READ_HITS]    = dmcc_pkg::BLK_W'(hit && !it_write_q);
    amt[dmcc_pkg::CNT_READ_MISSES]  = dmcc_pkg::BLK_W'(!hit && !it_write_q);
    amt[dmcc_pkg::CNT_WRITE_HITS]   = dmcc_pkg::BLK_W'(hit && it_write_q);
    amt[dmcc_pkg::CNT_WRITE_MISSES] = dmcc_pkg::BLK_W'(!hit && it_write_q);
  end

  // Saturating counter update
  always_comb begin
    for (int k = 0; k < dmcc_pkg::NUM_CNT; k++) begin
      cnt_d[k] = look_fire ? dmcc_pkg::sat_add(cnt_q[k], amt[k]) : cnt_q[k];
    end
  end

  // Line store write: clear sweep or line update
  always_comb begin
    mem_we = 1'b0;
    mem_wa = it_idx_q;
    mem_wd = {1'b1, dirty_new, it_tag_q};
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = '0;
    end else if (look_fire) begin
      mem_we = 1'b1;
    end
  end

  // Sequence clear, lookup and update
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!res_full_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
    end
  end

  // Hold the popped item
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      it_write_q <= q_is_write_i;
      it_ob_q    <= q_ob_i;
      it_idx_q   <= q_idx_i;
      it_tag_q   <= q_tag_i;
    end
  end

  // Line store ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem_q[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    line_rd_q <= line_mem_q[rd_addr];
  end

  // Result beat
  assign res_push_o            = look_fire;
  assign res_data_o.hit        = hit;
  assign res_data_o.wrote_back = victim;
  assign res_data_o.cnt        = cnt_d;

  assign status_o.clearing = (state_q == S_CLEAR);
  assign status_o.busy     = (state_q == S_LOOK);

endmodule
